// ----- src/fpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types, constants, quarter-wave ROM and helper functions of the
// fixed-point trigonometry unit.
// ----------------------------------------------------------------------------
package fpt_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int LUT_ADDR_BITS = 9;
  localparam int QUAD_BITS     = FRAC_BITS - 2;
  localparam int ROM_SHIFT     = QUAD_BITS - LUT_ADDR_BITS;
  localparam int ROM_SIZE      = 1 << LUT_ADDR_BITS;
  localparam int MAG_W         = FRAC_BITS + 1;
  localparam int DIV_STEPS     = MAG_W + FRAC_BITS;
  localparam int VAL_W         = 32;

  // Operation codes.
  localparam logic [2:0] OP_SIN     = 3'd0;
  localparam logic [2:0] OP_COS     = 3'd1;
  localparam logic [2:0] OP_TAN     = 3'd2;
  localparam logic [2:0] OP_TRI_SIN = 3'd3;
  localparam logic [2:0] OP_TRI_COS = 3'd4;
  localparam logic [2:0] OP_TRI_TAN = 3'd5;

  // Decoded angle: sign, quadrant and position inside the quadrant.
  typedef struct packed {
    logic                 neg;
    logic [1:0]           quad;
    logic [QUAD_BITS-1:0] pos;
  } ang_t;

  // Sign and magnitude of one wave sample.
  typedef struct packed {
    logic             sgn;
    logic [MAG_W-1:0] mag;
  } wave_t;

  // Sine and cosine samples of one item, passed from the front end.
  typedef struct packed {
    logic [2:0] op;
    wave_t      s;
    wave_t      c;
  } front_t;

  // Side information that travels alongside the divider.
  typedef struct packed {
    logic             qneg;
    logic             is_tan;
    logic             undef;
    logic [VAL_W-1:0] alt;
  } div_side_t;

  localparam logic [15:0] QROM [ROM_SIZE] = '{
    16'h0000, 16'h00C9, 16'h0192, 16'h025B, 16'h0324, 16'h03ED, 16'h04B6, 16'h057F,
    16'h0648, 16'h0711, 16'h07DA, 16'h08A3, 16'h096C, 16'h0A35, 16'h0AFE, 16'h0BC6,
    16'h0C8F, 16'h0D58, 16'h0E21, 16'h0EEA, 16'h0FB2, 16'h107B, 16'h1144, 16'h120C,
    16'h12D5, 16'h139D, 16'h1466, 16'h152E, 16'h15F6, 16'h16BF, 16'h1787, 16'h184F,
    16'h1917, 16'h19DF, 16'h1AA7, 16'h1B6F, 16'h1C37, 16'h1CFF, 16'h1DC7, 16'h1E8E,
    16'h1F56, 16'h201D, 16'h20E5, 16'h21AC, 16'h2273, 16'h233B, 16'h2402, 16'h24C9,
    16'h2590, 16'h2656, 16'h271D, 16'h27E4, 16'h28AA, 16'h2971, 16'h2A37, 16'h2AFE,
    16'h2BC4, 16'h2C8A, 16'h2D50, 16'h2E15, 16'h2EDB, 16'h2FA1, 16'h3066, 16'h312C,
    16'h31F1, 16'h32B6, 16'h337B, 16'h3440, 16'h3505, 16'h35C9, 16'h368E, 16'h3752,
    16'h3817, 16'h38DB, 16'h399F, 16'h3A62, 16'h3B26, 16'h3BEA, 16'h3CAD, 16'h3D70,
    16'h3E33, 16'h3EF6, 16'h3FB9, 16'h407C, 16'h413E, 16'h4201, 16'h42C3, 16'h4385,
    16'h4447, 16'h4508, 16'h45CA, 16'h468B, 16'h474D, 16'h480E, 16'h48CE, 16'h498F,
    16'h4A50, 16'h4B10, 16'h4BD0, 16'h4C90, 16'h4D50, 16'h4E0F, 16'h4ECF, 16'h4F8E,
    16'h504D, 16'h510C, 16'h51CA, 16'h5289, 16'h5347, 16'h5405, 16'h54C3, 16'h5581,
    16'h563E, 16'h56FB, 16'h57B8, 16'h5875, 16'h5931, 16'h59EE, 16'h5AAA, 16'h5B66,
    16'h5C22, 16'h5CDD, 16'h5D98, 16'h5E53, 16'h5F0E, 16'h5FC9, 16'h6083, 16'h613D,
    16'h61F7, 16'h62B1, 16'h636A, 16'h6423, 16'h64DC, 16'h6595, 16'h664D, 16'h6705,
    16'h67BD, 16'h6875, 16'h692D, 16'h69E4, 16'h6A9B, 16'h6B51, 16'h6C08, 16'h6CBE,
    16'h6D74, 16'h6E29, 16'h6EDF, 16'h6F94, 16'h7049, 16'h70FD, 16'h71B1, 16'h7265,
    16'h7319, 16'h73CD, 16'h7480, 16'h7533, 16'h75E5, 16'h7698, 16'h774A, 16'h77FB,
    16'h78AD, 16'h795E, 16'h7A0F, 16'h7AC0, 16'h7B70, 16'h7C20, 16'h7CD0, 16'h7D7F,
    16'h7E2E, 16'h7EDD, 16'h7F8B, 16'h803A, 16'h80E7, 16'h8195, 16'h8242, 16'h82EF,
    16'h839C, 16'h8448, 16'h84F4, 16'h85A0, 16'h864B, 16'h86F6, 16'h87A1, 16'h884B,
    16'h88F5, 16'h899F, 16'h8A48, 16'h8AF1, 16'h8B9A, 16'h8C42, 16'h8CEA, 16'h8D92,
    16'h8E39, 16'h8EE0, 16'h8F87, 16'h902D, 16'h90D3, 16'h9179, 16'h921E, 16'h92C3,
    16'h9368, 16'h940C, 16'h94B0, 16'h9553, 16'h95F6, 16'h9699, 16'h973C, 16'h97DE,
    16'h987F, 16'h9921, 16'h99C2, 16'h9A62, 16'h9B02, 16'h9BA2, 16'h9C42, 16'h9CE1,
    16'h9D7F, 16'h9E1E, 16'h9EBC, 16'h9F59, 16'h9FF6, 16'hA093, 16'hA12F, 16'hA1CB,
    16'hA267, 16'hA302, 16'hA39D, 16'hA438, 16'hA4D2, 16'hA56B, 16'hA605, 16'hA69D,
    16'hA736, 16'hA7CE, 16'hA866, 16'hA8FD, 16'hA994, 16'hAA2A, 16'hAAC0, 16'hAB56,
    16'hABEB, 16'hAC80, 16'hAD14, 16'hADA8, 16'hAE3B, 16'hAECE, 16'hAF61, 16'hAFF3,
    16'hB085, 16'hB117, 16'hB1A8, 16'hB238, 16'hB2C8, 16'hB358, 16'hB3E7, 16'hB476,
    16'hB504, 16'hB592, 16'hB620, 16'hB6AD, 16'hB73A, 16'hB7C6, 16'hB852, 16'hB8DD,
    16'hB968, 16'hB9F2, 16'hBA7C, 16'hBB06, 16'hBB8F, 16'hBC17, 16'hBCA0, 16'hBD27,
    16'hBDAE, 16'hBE35, 16'hBEBC, 16'hBF41, 16'hBFC7, 16'hC04C, 16'hC0D0, 16'hC154,
    16'hC1D8, 16'hC25B, 16'hC2DE, 16'hC360, 16'hC3E2, 16'hC463, 16'hC4E3, 16'hC564,
    16'hC5E4, 16'hC663, 16'hC6E2, 16'hC760, 16'hC7DE, 16'hC85B, 16'hC8D8, 16'hC955,
    16'hC9D1, 16'hCA4C, 16'hCAC7, 16'hCB41, 16'hCBBB, 16'hCC35, 16'hCCAE, 16'hCD26,
    16'hCD9F, 16'hCE16, 16'hCE8D, 16'hCF04, 16'hCF7A, 16'hCFEF, 16'hD064, 16'hD0D9,
    16'hD14D, 16'hD1C0, 16'hD233, 16'hD2A6, 16'hD318, 16'hD389, 16'hD3FA, 16'hD46B,
    16'hD4DB, 16'hD54A, 16'hD5B9, 16'hD627, 16'hD695, 16'hD703, 16'hD770, 16'hD7DC,
    16'hD848, 16'hD8B3, 16'hD91E, 16'hD988, 16'hD9F2, 16'hDA5B, 16'hDAC4, 16'hDB2C,
    16'hDB94, 16'hDBFB, 16'hDC61, 16'hDCC7, 16'hDD2D, 16'hDD92, 16'hDDF6, 16'hDE5A,
    16'hDEBE, 16'hDF20, 16'hDF83, 16'hDFE4, 16'hE046, 16'hE0A6, 16'hE106, 16'hE166,
    16'hE1C5, 16'hE224, 16'hE282, 16'hE2DF, 16'hE33C, 16'hE398, 16'hE3F4, 16'hE44F,
    16'hE4AA, 16'hE504, 16'hE55E, 16'hE5B7, 16'hE60F, 16'hE667, 16'hE6BE, 16'hE715,
    16'hE76B, 16'hE7C1, 16'hE816, 16'hE86B, 16'hE8BF, 16'hE912, 16'hE965, 16'hE9B7,
    16'hEA09, 16'hEA5A, 16'hEAAB, 16'hEAFB, 16'hEB4B, 16'hEB99, 16'hEBE8, 16'hEC36,
    16'hEC83, 16'hECD0, 16'hED1C, 16'hED67, 16'hEDB2, 16'hEDFC, 16'hEE46, 16'hEE8F,
    16'hEED8, 16'hEF20, 16'hEF68, 16'hEFAF, 16'hEFF5, 16'hF03B, 16'hF080, 16'hF0C5,
    16'hF109, 16'hF14C, 16'hF18F, 16'hF1D1, 16'hF213, 16'hF254, 16'hF294, 16'hF2D4,
    16'hF314, 16'hF353, 16'hF391, 16'hF3CE, 16'hF40B, 16'hF448, 16'hF484, 16'hF4BF,
    16'hF4FA, 16'hF534, 16'hF56D, 16'hF5A6, 16'hF5DE, 16'hF616, 16'hF64D, 16'hF684,
    16'hF6BA, 16'hF6EF, 16'hF724, 16'hF758, 16'hF78B, 16'hF7BE, 16'hF7F1, 16'hF822,
    16'hF853, 16'hF884, 16'hF8B4, 16'hF8E3, 16'hF912, 16'hF940, 16'hF96E, 16'hF99B,
    16'hF9C7, 16'hF9F3, 16'hFA1E, 16'hFA49, 16'hFA73, 16'hFA9C, 16'hFAC5, 16'hFAED,
    16'hFB14, 16'hFB3B, 16'hFB61, 16'hFB87, 16'hFBAC, 16'hFBD1, 16'hFBF5, 16'hFC18,
    16'hFC3B, 16'hFC5D, 16'hFC7E, 16'hFC9F, 16'hFCBF, 16'hFCDF, 16'hFCFE, 16'hFD1C,
    16'hFD3A, 16'hFD57, 16'hFD74, 16'hFD90, 16'hFDAB, 16'hFDC6, 16'hFDE0, 16'hFDFA,
    16'hFE13, 16'hFE2B, 16'hFE43, 16'hFE5A, 16'hFE70, 16'hFE86, 16'hFE9B, 16'hFEB0,
    16'hFEC4, 16'hFED7, 16'hFEEA, 16'hFEFC, 16'hFF0E, 16'hFF1F, 16'hFF2F, 16'hFF3F,
    16'hFF4E, 16'hFF5C, 16'hFF6A, 16'hFF78, 16'hFF84, 16'hFF90, 16'hFF9C, 16'hFFA6,
    16'hFFB1, 16'hFFBA, 16'hFFC3, 16'hFFCB, 16'hFFD3, 16'hFFDA, 16'hFFE1, 16'hFFE7,
    16'hFFEC, 16'hFFF0, 16'hFFF4, 16'hFFF8, 16'hFFFB, 16'hFFFD, 16'hFFFE, 16'hFFFF
  };

  // Split a raw angle into sign, quadrant and position of its magnitude.
  function automatic ang_t decode_angle(input logic [VAL_W-1:0] raw);
    ang_t                 a;
    logic [FRAC_BITS-1:0] frac;
    frac   = raw[VAL_W-1] ? (FRAC_BITS'(0) - raw[FRAC_BITS-1:0]) : raw[FRAC_BITS-1:0];
    a.neg  = raw[VAL_W-1];
    a.quad = frac[FRAC_BITS-1 -: 2];
    a.pos  = frac[QUAD_BITS-1:0];
    return a;
  endfunction

  // Sign and magnitude of the ROM or triangle sine at a decoded angle.
  function automatic wave_t wave_sample(input ang_t a, input logic tri_sel);
    wave_t                    w;
    logic [LUT_ADDR_BITS-1:0] addr;
    logic [MAG_W-1:0]         ramp;
    addr = a.pos[QUAD_BITS-1 -: LUT_ADDR_BITS];
    ramp = MAG_W'({a.pos, 2'b00});
    w.sgn = a.neg ^ a.quad[1];
    if (tri_sel) begin
      w.mag = a.quad[0] ? ((MAG_W'(1) << FRAC_BITS) - ramp) : ramp;
    end else if (!a.quad[0]) begin
      w.mag = MAG_W'(QROM[addr]);
    end else if (addr == '0) begin
      w.mag = MAG_W'(1) << FRAC_BITS;
    end else begin
      w.mag = MAG_W'(QROM[LUT_ADDR_BITS'(0) - addr]);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- src/fixed_point_trig_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_trig_unit
// Sine, cosine and tangent (ROM or triangle wave) of 16.16 angles in turns.
// ----------------------------------------------------------------------------
// The unit takes one transfer per cycle while the output is not stalled and
// returns one result per input, in order, through two front stages (angle
// decode and quarter-wave ROM lookup), one stage that forms the signed samples
// and the divider operands, 33 stages of the tangent divider that produce one
// quotient bit each, and the output register. All operations run through the
// same pipeline so results never reorder. Backpressure on the output stalls
// the whole pipeline; s_axis_tready is low only while a result waits.
module fixed_point_trig_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] angle
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] value
  output logic             m_axis_tuser   // [0] undefined
);
  import fpt_pkg::*;

  logic                 adv;
  logic                 fv;
  front_t               fd;
  logic                 v3_q;
  logic [DIV_STEPS-1:0] num_q;
  logic [MAG_W-1:0]     den_q;
  div_side_t            side_q;
  logic                 dv;
  logic [DIV_STEPS-1:0] quo;
  div_side_t            dside;
  logic [VAL_W-1:0]     s_val, c_val, alt_d, val_d, qmag;
  logic                 m_valid_q;
  logic [VAL_W-1:0]     m_data_q;
  logic                 m_user_q;

  // The pipeline moves whenever the output register is free or drained.
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  fpt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .op_i    (s_axis_tuser),
    .angle_i (s_axis_tdata),
    .valid_o (fv),
    .data_o  (fd)
  );

  // Signed sample values.
  assign s_val = fd.s.sgn ? (VAL_W'(0) - VAL_W'(fd.s.mag)) : VAL_W'(fd.s.mag);
  assign c_val = fd.c.sgn ? (VAL_W'(0) - VAL_W'(fd.c.mag)) : VAL_W'(fd.c.mag);

  // Non-tangent result selected by operation.
  always_comb begin
    case (fd.op)
      OP_SIN, OP_TRI_SIN: alt_d = s_val;
      OP_COS, OP_TRI_COS: alt_d = c_val;
      default:            alt_d = '0;
    endcase
  end

  // Operand stage for the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= fv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q         <= {fd.s.mag, FRAC_BITS'(0)};
      den_q         <= fd.c.mag;
      side_q.qneg   <= fd.s.sgn ^ fd.c.sgn;
      side_q.is_tan <= (fd.op == OP_TAN) || (fd.op == OP_TRI_TAN);
      side_q.undef  <= fd.c.mag == '0;
      side_q.alt    <= alt_d;
    end
  end

  fpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (dside)
  );

  // Final selection: the quotient magnitude always fits below 2^31.
  assign qmag = quo[VAL_W-1:0];
  always_comb begin
    if (!dside.is_tan) begin
      val_d = dside.alt;
    end else if (dside.undef) begin
      val_d = '1;
    end else begin
      val_d = dside.qneg ? (VAL_W'(0) - qmag) : qmag;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= val_d;
      m_user_q <= dside.is_tan && dside.undef;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

// ----- src/fpt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_front
// Two pipeline stages: angle decode for sine and cosine, then ROM or
// triangle lookup giving sign and magnitude of both samples.
// ----------------------------------------------------------------------------
module fpt_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [2:0]            op_i,
  input  wire logic [31:0]           angle_i,
  output logic                       valid_o,
  output fpt_pkg::front_t            data_o
);
  import fpt_pkg::*;

  logic       v1_q, v2_q;
  logic [2:0] op1_q;
  ang_t       sa_q, ca_q;
  front_t     f2_q;
  logic [VAL_W-1:0] cos_raw;

  // The cosine angle is the input plus a quarter turn, wrapping.
  assign cos_raw = angle_i + (VAL_W'(1) << QUAD_BITS);

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Decode stage and lookup stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q     <= op_i;
      sa_q      <= decode_angle(angle_i);
      ca_q      <= decode_angle(cos_raw);
      f2_q.op   <= op1_q;
      f2_q.s    <= wave_sample(sa_q, op1_q >= OP_TRI_SIN);
      f2_q.c    <= wave_sample(ca_q, op1_q >= OP_TRI_SIN);
    end
  end

  assign valid_o = v2_q;
  assign data_o  = f2_q;

endmodule
`default_nettype wire

// ----- src/fpt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_div
// Pipelined restoring divider of magnitudes, one quotient bit per stage,
// with side information carried alongside.
// ----------------------------------------------------------------------------
module fpt_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [fpt_pkg::DIV_STEPS-1:0] num_i,
  input  wire logic [fpt_pkg::MAG_W-1:0]   den_i,
  input  wire fpt_pkg::div_side_t          side_i,
  output logic                             valid_o,
  output logic [fpt_pkg::DIV_STEPS-1:0]    quo_o,
  output fpt_pkg::div_side_t               side_o
);
  import fpt_pkg::*;

  logic                 v_q    [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] acc_q  [DIV_STEPS+1];
  logic [MAG_W-1:0]     rem_q  [DIV_STEPS+1];
  logic [MAG_W-1:0]     den_q  [DIV_STEPS+1];
  div_side_t            side_q [DIV_STEPS+1];

  // Stage zero is the input itself.
  always_comb begin
    v_q[0]    = valid_i;
    acc_q[0]  = num_i;
    rem_q[0]  = '0;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MAG_W:0] trial;
    logic           fit;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_q[k], acc_q[k][DIV_STEPS-1]};
    assign fit   = trial >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= fit ? MAG_W'(trial - {1'b0, den_q[k]}) : MAG_W'(trial);
        acc_q[k+1]  <= {acc_q[k][DIV_STEPS-2:0], fit};
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS];
  assign quo_o   = acc_q[DIV_STEPS];
  assign side_o  = side_q[DIV_STEPS];

endmodule
`default_nettype wire

// ----- src/fpt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_checker
// Port-level checks of the trigonometry unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An undefined tangent always reports raw minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'hFFFF_FFFF)
    else $error("undefined flag without minus one");

  // Input is refused only while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind fixed_point_trig_unit fpt_checker u_fpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/sv/tb_fixed_point_trig_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_trig_unit
// Self-checking bench for the fixed-point trigonometry unit: directed corner
// angles and random operations are streamed in with random gaps and output
// stalls, and every result is compared with a behavioral trig predictor.
// ----------------------------------------------------------------------------
module tb_fixed_point_trig_unit;
  import fpt_pkg::*;

  // Reference ROM of one quarter wave, taken from the package ROM of the unit.
  localparam logic [15:0] SINE_ROM [512] = fpt_pkg::QROM;

  typedef struct {
    logic [31:0] value;
    logic        undefined;
  } trig_result_t;

  // Scoreboard: predicts each accepted item and checks results in order.
  class trig_scoreboard;
    trig_result_t pending[$];
    int           mismatches;

    function automatic int signed sine_of(logic [31:0] raw, bit tri_wave);
      logic        neg;
      logic [31:0] mag;
      logic [15:0] frac;
      logic [1:0]  quad;
      int signed   pos;
      int signed   r;
      logic [8:0]  addr;
      neg  = raw[31];
      mag  = neg ? (32'd0 - raw) : raw;
      frac = mag[15:0];
      quad = frac[15:14];
      pos  = int'(frac[13:0]);
      if (tri_wave) begin
        case (quad)
          2'd0: r = 4 * pos;
          2'd1: r = 65536 - 4 * pos;
          2'd2: r = -4 * pos;
          default: r = 4 * pos - 65536;
        endcase
      end else begin
        addr = frac[13:5];
        if (!quad[0]) r = int'(SINE_ROM[addr]);
        else if (addr == 9'd0) r = 65536;
        else r = int'(SINE_ROM[9'd0 - addr]);
        if (quad[1]) r = -r;
      end
      return neg ? -r : r;
    endfunction

    function automatic trig_result_t predict(logic [2:0] op, logic [31:0] ang);
      trig_result_t    res;
      bit              tri_wave;
      longint signed   s;
      longint signed   c;
      longint signed   q;
      tri_wave      = (op >= OP_TRI_SIN);
      res.value     = '0;
      res.undefined = 1'b0;
      s = sine_of(ang, tri_wave);
      c = sine_of(ang + 32'h4000, tri_wave);
      case (op)
        OP_SIN, OP_TRI_SIN: res.value = s[31:0];
        OP_COS, OP_TRI_COS: res.value = c[31:0];
        OP_TAN, OP_TRI_TAN: begin
          if (c == 0) begin
            res.value     = 32'hFFFF_FFFF;
            res.undefined = 1'b1;
          end else begin
            // SystemVerilog division truncates toward zero.
            q = (s * 65536) / c;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            res.value = q[31:0];
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(logic [2:0] op, logic [31:0] ang);
      pending.push_back(predict(op, ang));
    endfunction

    function void check_result(logic [31:0] value, logic undefined);
      trig_result_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", value);
        return;
      end
      exp_res = pending.pop_front();
      if (exp_res.value !== value || exp_res.undefined !== undefined) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h/%b, got %h/%b",
                   exp_res.value, exp_res.undefined, value, undefined);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  trig_scoreboard trig_sb = new();
  bit             no_idle_phase = 1'b0;
  int             hold_off_cycles = 0;

  always #1 clk_i = ~clk_i;

  fixed_point_trig_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Note accepted inputs and check accepted results at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      trig_sb.note_input(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      trig_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= no_idle_phase || ($urandom_range(99) >= 16);
    end
  end

  // Offer one transfer and hold it until accepted.
  task automatic send_angle(logic [2:0] op, logic [31:0] ang);
    while (!no_idle_phase && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= ang;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_angle();
    logic [31:0] a;
    a = $urandom();
    case ($urandom_range(3))
      0: a[15:0] = {a[15:14], 9'd0, a[4:0]} & 16'hC01F;
      1: a[15:0] = {a[15:14], 14'd0};
      default: ;
    endcase
    if (a == 32'h8000_0000) a = 32'h8000_0001;
    return a;
  endfunction

  initial begin
    logic [31:0] corners[$];
    logic [2:0]  op;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, quadrant borders and quarter-offset wrap.
    corners = '{32'h0, 32'h4000, 32'h8000, 32'hC000, 32'h7FFF_FFFF, 32'h8000_0001,
                32'hFFFF_C000, 32'h7FFF_C000, 32'h0000_FFFF, 32'h0000_0020};
    foreach (corners[i]) send_angle(3'(i % 6), corners[i]);
    for (int o = 0; o < 8; o++) send_angle(3'(o), 32'hFFFF_4000);
    send_angle(OP_TAN, 32'h4000);
    send_angle(OP_TRI_TAN, 32'hFFFF_C000);
    s_axis_tvalid <= 1'b0;

    // Sender pauses until every expected result is back.
    while (trig_sb.pending.size() != 0) @(negedge clk_i);

    for (int n = 0; n < 1400; n++) begin
      if (n == 200) hold_off_cycles <= 120;
      no_idle_phase = (n >= 600 && n < 800);
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_angle(op, random_angle());
    end
    s_axis_tvalid <= 1'b0;
    no_idle_phase = 1'b0;

    while (trig_sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (trig_sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
